// ===== rtl/ilda_laser_frame_stream_parser_core_defines.svh =====
// Assertion helpers shared by the parser RTL.
// Each macro checks on the rising edge of clk and is disabled while rst is high.
`ifndef ILDA_LASER_FRAME_STREAM_PARSER_CORE_DEFINES_SVH
`define ILDA_LASER_FRAME_STREAM_PARSER_CORE_DEFINES_SVH

// Same-cycle implication.
`define ILDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ILDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ilda_pkg.sv =====
package ilda_pkg;

  // Palette storage
  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int PAL_CW        = PAL_AW + 1;

  // Result kinds
  localparam logic [1:0] KIND_POINT   = 2'd0;
  localparam logic [1:0] KIND_BAD_SIG = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  // Section format codes
  localparam logic [31:0] FMT_3D_IDX   = 32'd0;
  localparam logic [31:0] FMT_2D_IDX   = 32'd1;
  localparam logic [31:0] FMT_PALETTE  = 32'd2;
  localparam logic [31:0] FMT_TC_TABLE = 32'd3;
  localparam logic [31:0] FMT_3D_TC    = 32'd4;
  localparam logic [31:0] FMT_2D_TC    = 32'd5;

  // Header byte offsets
  localparam logic [4:0] SIG_LAST      = 5'd3;
  localparam logic [4:0] FMT_LAST      = 5'd3;
  localparam logic [4:0] HDR_COUNT_HI  = 5'd16;
  localparam logic [4:0] HDR_COUNT_LO  = 5'd17;
  localparam logic [4:0] HDR_LAST      = 5'd23;
  localparam logic [4:0] SHORT_HDR_MID = 5'd4;
  localparam logic [4:0] SHORT_HDR_END = 5'd7;
  localparam logic [4:0] TRIPLE_LAST   = 5'd2;

  // Point record sizes
  localparam logic [4:0] COORD_3D_BYTES = 5'd6;
  localparam logic [4:0] COORD_2D_BYTES = 5'd4;
  localparam logic [4:0] TAIL_TC_BYTES  = 5'd4;
  localparam logic [4:0] TAIL_IDX_BYTES = 5'd2;

  localparam logic [7:0] SIG_BYTES [4] = '{8'h49, 8'h4C, 8'h44, 8'h41};

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } byte_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               blanked;
    logic               has_color;
    logic [7:0]         color_index;
    logic [15:0]        frame_number;
    logic               last_point;
  } point_t;

endpackage

// ===== rtl/ilda_laser_frame_stream_parser_core.sv =====
// Laser-show file stream parser.
// Input channel (byte_valid / byte_stall / byte_data): one file byte per transfer,
// with restart set on the first byte of a new file. restart clears the parse state
// and empties the palette; that same byte is parsed as the first byte of the file.
// Output channel (point_valid / point_stall / point_data): one point record per
// parsed point, or one halt record on a bad signature, an empty frame or an empty true-color table.
// Throughput: one byte per cycle unless stalled; the parse state advances on every
// transfer and the palette lookup for the next point is fetched from its RAM
// well ahead of that point's last byte (a record is at least six bytes long).
// A result is registered into the output register, or into the skid entry when the
// output register is held, on the transfer of the byte that completes it.
// When the receiver stalls, the output register holds and one more result can
// land in a skid entry; byte_stall is high only while the skid entry is full.
// After a halt record every byte is consumed and dropped until restart.
// Reset (rst, synchronous): parser returns to the signature phase, palette empty,
// frame counter zero, both output entries empty. Palette RAM contents are kept.
`include "ilda_laser_frame_stream_parser_core_defines.svh"

module ilda_laser_frame_stream_parser_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            byte_valid,
  output logic            byte_stall,
  input  ilda_pkg::byte_t byte_data,
  output logic            point_valid,
  input  logic            point_stall,
  output ilda_pkg::point_t point_data
);
  import ilda_pkg::*;

  typedef enum logic [9:0] {
    PH_SIG       = 10'b0000000001,
    PH_FMT       = 10'b0000000010,
    PH_FRAME_HDR = 10'b0000000100,
    PH_POINT     = 10'b0000001000,
    PH_PAL_HDR   = 10'b0000010000,
    PH_TC_HDR    = 10'b0000100000,
    PH_TABLE     = 10'b0001000000,
    PH_UNK_HDR   = 10'b0010000000,
    PH_SKIP      = 10'b0100000000,
    PH_HALT      = 10'b1000000000
  } phase_t;

  // Parse state
  phase_t              phase, phase_next, c_phase;
  logic [4:0]          pos, pos_next, c_pos;
  logic [31:0]         fmt, fmt_next, c_fmt;
  logic [15:0]         entry_total, entry_total_next, c_entry_total;
  logic [15:0]         points_done, points_done_next, c_points_done;
  logic [31:0]         remaining, remaining_next, c_remaining;
  logic [47:0]         coord, coord_next, c_coord;
  logic [31:0]         stat_col, stat_col_next, c_stat_col;
  logic [PAL_CW-1:0]   pal_cnt, pal_cnt_next, c_pal_cnt;
  logic [15:0]         frame_cnt, frame_cnt_next, c_frame_cnt;
  logic                sig_bad, sig_bad_next, c_sig_bad;
  logic [23:0]         triple, triple_next, c_triple;

  // Palette RAM, one write and one registered read port
  logic [23:0]         palette [PALETTE_DEPTH];
  logic [23:0]         pal_rdata;
  logic                pal_we;
  logic [PAL_AW-1:0]   pal_waddr;

  // Output register and skid entry
  point_t              out_reg, skid_reg, res;
  logic                out_valid, skid_valid, res_valid;

  logic                acc, out_take;
  logic [7:0]          b;
  logic                is_3d, is_true;
  logic [4:0]          cbytes, rec_len;
  logic [7:0]          status;

  assign acc         = byte_valid && !byte_stall;
  assign out_take    = out_valid && !point_stall;
  assign byte_stall  = skid_valid;
  assign point_valid = out_valid;
  assign point_data  = out_reg;
  assign b           = byte_data.data_byte;

  // Next-state logic: restart applies before the byte is parsed
  always_comb begin
    c_phase       = byte_data.restart ? PH_SIG : phase;
    c_pos         = byte_data.restart ? '0 : pos;
    c_fmt         = byte_data.restart ? '0 : fmt;
    c_entry_total = byte_data.restart ? '0 : entry_total;
    c_points_done = byte_data.restart ? '0 : points_done;
    c_remaining   = byte_data.restart ? '0 : remaining;
    c_coord       = byte_data.restart ? '0 : coord;
    c_stat_col    = byte_data.restart ? '0 : stat_col;
    c_pal_cnt     = byte_data.restart ? '0 : pal_cnt;
    c_frame_cnt   = byte_data.restart ? '0 : frame_cnt;
    c_sig_bad     = byte_data.restart ? 1'b0 : sig_bad;
    c_triple      = byte_data.restart ? '0 : triple;

    phase_next       = c_phase;
    pos_next         = c_pos;
    fmt_next         = c_fmt;
    entry_total_next = c_entry_total;
    points_done_next = c_points_done;
    remaining_next   = c_remaining;
    coord_next       = c_coord;
    stat_col_next    = c_stat_col;
    pal_cnt_next     = c_pal_cnt;
    frame_cnt_next   = c_frame_cnt;
    sig_bad_next     = c_sig_bad;
    triple_next      = c_triple;

    pal_we    = 1'b0;
    pal_waddr = c_pal_cnt[PAL_AW-1:0];
    res_valid = 1'b0;
    res       = '0;
    status    = '0;

    is_3d   = (c_fmt == FMT_3D_IDX) || (c_fmt == FMT_3D_TC);
    is_true = (c_fmt == FMT_3D_TC) || (c_fmt == FMT_2D_TC);
    cbytes  = is_3d ? COORD_3D_BYTES : COORD_2D_BYTES;
    rec_len = cbytes + (is_true ? TAIL_TC_BYTES : TAIL_IDX_BYTES);

    unique case (c_phase)
      PH_SIG: begin
        sig_bad_next = c_sig_bad || (b != SIG_BYTES[c_pos[1:0]]);
        pos_next     = c_pos + 5'd1;
        if (c_pos >= SIG_LAST) begin
          if (sig_bad_next) begin
            res_valid  = 1'b1;
            res.kind   = KIND_BAD_SIG;
            phase_next = PH_HALT;
          end else begin
            phase_next = PH_FMT;
            pos_next   = '0;
            fmt_next   = '0;
          end
        end
      end
      PH_FMT: begin
        fmt_next = {c_fmt[23:0], b};
        pos_next = c_pos + 5'd1;
        if (c_pos >= FMT_LAST) begin
          entry_total_next = '0;
          remaining_next   = '0;
          pos_next         = '0;
          if (fmt_next <= FMT_2D_IDX || fmt_next == FMT_3D_TC || fmt_next == FMT_2D_TC) begin
            phase_next = PH_FRAME_HDR;
          end else if (fmt_next == FMT_PALETTE) begin
            phase_next = PH_PAL_HDR;
          end else if (fmt_next == FMT_TC_TABLE) begin
            phase_next = PH_TC_HDR;
          end else begin
            phase_next = PH_UNK_HDR;
          end
        end
      end
      PH_FRAME_HDR: begin
        if (c_pos == HDR_COUNT_HI || c_pos == HDR_COUNT_LO) begin
          entry_total_next = {c_entry_total[7:0], b};
        end
        pos_next = c_pos + 5'd1;
        if (c_pos >= HDR_LAST) begin
          if (entry_total_next == '0) begin
            res_valid  = 1'b1;
            res.kind   = KIND_END;
            phase_next = PH_HALT;
          end else begin
            points_done_next = '0;
            coord_next       = '0;
            stat_col_next    = '0;
            phase_next       = PH_POINT;
            pos_next         = '0;
          end
        end
      end
      PH_POINT: begin
        if (c_pos < cbytes) begin
          coord_next = {c_coord[39:0], b};
        end else begin
          stat_col_next = {c_stat_col[23:0], b};
        end
        pos_next = c_pos + 5'd1;
        if (pos_next >= rec_len) begin
          res_valid = 1'b1;
          res.kind  = KIND_POINT;
          if (is_3d) begin
            res.pos_x = coord_next[47:32];
            res.pos_y = coord_next[31:16];
            res.pos_z = coord_next[15:0];
          end else begin
            res.pos_x = coord_next[31:16];
            res.pos_y = coord_next[15:0];
          end
          if (is_true) begin
            status        = stat_col_next[31:24];
            res.blue      = stat_col_next[23:16];
            res.green     = stat_col_next[15:8];
            res.red       = stat_col_next[7:0];
            res.has_color = 1'b1;
          end else begin
            status          = stat_col_next[15:8];
            res.color_index = stat_col_next[7:0];
            // Palette entry is looked up by point position within the frame
            if (32'(c_points_done) < 32'(c_pal_cnt)) begin
              res.red       = pal_rdata[23:16];
              res.green     = pal_rdata[15:8];
              res.blue      = pal_rdata[7:0];
              res.has_color = 1'b1;
            end
          end
          res.blanked      = status[6];
          res.frame_number = c_frame_cnt;
          res.last_point   = ({1'b0, c_points_done} + 17'd1) == {1'b0, c_entry_total};

          points_done_next = c_points_done + 16'd1;
          coord_next       = '0;
          stat_col_next    = '0;
          pos_next         = '0;
          if (points_done_next == c_entry_total) begin
            frame_cnt_next = c_frame_cnt + 16'd1;
            phase_next     = PH_SIG;
            sig_bad_next   = 1'b0;
          end
        end
      end
      PH_PAL_HDR: begin
        if (c_pos == HDR_COUNT_HI || c_pos == HDR_COUNT_LO) begin
          remaining_next = {16'd0, c_remaining[7:0], b};
        end
        pos_next = c_pos + 5'd1;
        if (c_pos >= HDR_LAST) begin
          pal_cnt_next = '0;
          pos_next     = '0;
          if (remaining_next == '0) begin
            phase_next   = PH_SIG;
            sig_bad_next = 1'b0;
          end else begin
            triple_next = '0;
            phase_next  = PH_TABLE;
          end
        end
      end
      PH_TC_HDR: begin
        if (c_pos >= SHORT_HDR_MID) begin
          remaining_next = {c_remaining[23:0], b};
        end
        pos_next = c_pos + 5'd1;
        if (c_pos >= SHORT_HDR_END) begin
          pal_cnt_next = '0;
          if (remaining_next == '0) begin
            res_valid  = 1'b1;
            res.kind   = KIND_END;
            phase_next = PH_HALT;
          end else begin
            triple_next = '0;
            phase_next  = PH_TABLE;
            pos_next    = '0;
          end
        end
      end
      PH_TABLE: begin
        triple_next = {c_triple[15:0], b};
        pos_next    = c_pos + 5'd1;
        if (c_pos >= TRIPLE_LAST) begin
          // Drop entries once the palette is full
          if (32'(c_pal_cnt) < PALETTE_DEPTH) begin
            pal_we       = 1'b1;
            pal_cnt_next = c_pal_cnt + PAL_CW'(1);
          end
          pos_next       = '0;
          remaining_next = c_remaining - 32'd1;
          if (remaining_next == '0) begin
            phase_next   = PH_SIG;
            sig_bad_next = 1'b0;
          end
        end
      end
      PH_UNK_HDR: begin
        if (c_pos < SHORT_HDR_MID) begin
          remaining_next = {c_remaining[23:0], b};
        end
        pos_next = c_pos + 5'd1;
        if (c_pos >= SHORT_HDR_END) begin
          pos_next = '0;
          // A negative length skips nothing
          if (remaining_next == '0 || remaining_next[31]) begin
            phase_next   = PH_SIG;
            sig_bad_next = 1'b0;
          end else begin
            phase_next = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        remaining_next = c_remaining - 32'd1;
        if (remaining_next == '0) begin
          phase_next   = PH_SIG;
          pos_next     = '0;
          sig_bad_next = 1'b0;
        end
      end
      PH_HALT: begin
        // Drop every byte until restart
      end
      default: begin
        phase_next = PH_HALT;
      end
    endcase
  end

  // Parse state registers: advance on each byte transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SIG;
      pos         <= '0;
      fmt         <= '0;
      entry_total <= '0;
      points_done <= '0;
      remaining   <= '0;
      coord       <= '0;
      stat_col    <= '0;
      pal_cnt     <= '0;
      frame_cnt   <= '0;
      sig_bad     <= 1'b0;
      triple      <= '0;
    end else if (acc) begin
      phase       <= phase_next;
      pos         <= pos_next;
      fmt         <= fmt_next;
      entry_total <= entry_total_next;
      points_done <= points_done_next;
      remaining   <= remaining_next;
      coord       <= coord_next;
      stat_col    <= stat_col_next;
      pal_cnt     <= pal_cnt_next;
      frame_cnt   <= frame_cnt_next;
      sig_bad     <= sig_bad_next;
      triple      <= triple_next;
    end
  end

  // Palette RAM: write completed triples, read ahead at the current point position
  always_ff @(posedge clk) begin
    if (acc && pal_we) begin
      palette[pal_waddr] <= triple_next;
    end
    pal_rdata <= palette[points_done[PAL_AW-1:0]];
  end

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_take) begin
          out_reg    <= skid_reg;
          skid_valid <= 1'b0;
        end
      end else if (acc && res_valid) begin
        if (!out_valid || out_take) begin
          out_reg   <= res;
          out_valid <= 1'b1;
        end else begin
          skid_reg   <= res;
          skid_valid <= 1'b1;
        end
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ILDA_ASSERT_NOW(a_skid_implies_out, skid_valid, out_valid, "skid full with empty output")
  `ILDA_ASSERT_NEXT(a_stalled_result_to_skid,
                    acc && res_valid && out_valid && point_stall, skid_valid,
                    "result lost while output stalled")
  `ILDA_ASSERT_NEXT(a_halt_holds, acc && phase == PH_HALT && !byte_data.restart,
                    phase == PH_HALT, "halt left without restart")
  `ILDA_ASSERT_NOW(a_pal_cnt_bound, 1'b1, 32'(pal_cnt) <= PALETTE_DEPTH,
                   "palette count beyond depth")

endmodule

// ===== sim/ilda_laser_frame_stream_parser_core_tb.sv =====
`timescale 1ns / 1ps

module ilda_laser_frame_stream_parser_core_tb;
  import ilda_pkg::*;

  localparam int IDLE_LIMIT   = 2000;  // cycles without any transfer
  localparam int TAIL_CYCLES  = 80;
  localparam int RANDOM_BYTES = 380;

  // Format codes outside the known set, used for skipped sections
  localparam logic [31:0] FMT_UNUSED   = 32'd6;
  localparam logic [31:0] FMT_ALL_ONES = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    ST_SIG, ST_FMT, ST_FRAME_HDR, ST_POINT, ST_PAL_HDR,
    ST_TC_HDR, ST_TABLE, ST_UNK_HDR, ST_SKIP, ST_HALT
  } parse_st_e;

  typedef enum logic [2:0] {
    SEC_FRAME, SEC_PALETTE, SEC_TC_TABLE, SEC_UNKNOWN, SEC_BAD_SIG
  } section_e;

  typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_EXTREME} fill_e;

  typedef struct packed {
    section_e    sec;
    logic        restart;     // restart flag on the first byte of the section
    logic [31:0] fmt;
    logic [31:0] count;       // entries, colors, or skip length
    fill_e       fill;        // content of free header bytes and records
    logic [1:0]  bad_at;      // corrupted signature byte
    logic        typed;       // expected halt record written in the row
    logic [1:0]  typed_kind;
  } plan_row_t;

  localparam int PLAN_ROWS = 22;

  // Directed sections: every format, halts, palette edge cases, skipped sections
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{SEC_FRAME,    1'b1, FMT_3D_IDX,    32'd2,          FILL_ZERO,    2'd0, 1'b0, KIND_POINT},
    '{SEC_PALETTE,  1'b0, FMT_PALETTE,   32'd3,          FILL_RANDOM,  2'd0, 1'b0, KIND_POINT},
    '{SEC_FRAME,    1'b0, FMT_3D_IDX,    32'd5,          FILL_RANDOM,  2'd0, 1'b0, KIND_POINT},
    '{SEC_FRAME,    1'b0, FMT_2D_IDX,    32'd2,          FILL_EXTREME, 2'd0, 1'b0, KIND_POINT},
    '{SEC_FRAME,    1'b0, FMT_3D_TC,     32'd2,          FILL_ONES,    2'd0, 1'b0, KIND_POINT},
    '{SEC_FRAME,    1'b0, FMT_2D_TC,     32'd3,          FILL_RANDOM,  2'd0, 1'b0, KIND_POINT},
    '{SEC_TC_TABLE, 1'b0, FMT_TC_TABLE,  32'd2,          FILL_RANDOM,  2'd0, 1'b0, KIND_POINT},
    '{SEC_FRAME,    1'b0, FMT_2D_IDX,    32'd3,          FILL_RANDOM,  2'd0, 1'b0, KIND_POINT},
    '{SEC_PALETTE,  1'b0, FMT_PALETTE,   32'd0,          FILL_RANDOM,  2'd0, 1'b0, KIND_POINT},
    '{SEC_FRAME,    1'b0, FMT_3D_IDX,    32'd2,          FILL_RANDOM,  2'd0, 1'b0, KIND_POINT},
    '{SEC_UNKNOWN,  1'b0, FMT_UNUSED,    32'd5,          FILL_RANDOM,  2'd0, 1'b0, KIND_POINT},
    '{SEC_UNKNOWN,  1'b0, FMT_UNUSED,    32'h8000_0003,  FILL_RANDOM,  2'd0, 1'b0, KIND_POINT},
    '{SEC_UNKNOWN,  1'b0, FMT_ALL_ONES,  32'd0,          FILL_ONES,    2'd0, 1'b0, KIND_POINT},
    '{SEC_PALETTE,  1'b0, FMT_PALETTE,   32'd9,          FILL_RANDOM,  2'd0, 1'b0, KIND_POINT},
    '{SEC_FRAME,    1'b0, FMT_2D_IDX,    32'd12,         FILL_RANDOM,  2'd0, 1'b0, KIND_POINT},
    '{SEC_FRAME,    1'b0, FMT_3D_TC,     32'd0,          FILL_RANDOM,  2'd0, 1'b1, KIND_END},
    '{SEC_FRAME,    1'b0, FMT_2D_TC,     32'd2,          FILL_RANDOM,  2'd0, 1'b0, KIND_POINT},
    '{SEC_BAD_SIG,  1'b1, FMT_3D_IDX,    32'd0,          FILL_RANDOM,  2'd3, 1'b1, KIND_BAD_SIG},
    '{SEC_FRAME,    1'b0, FMT_2D_IDX,    32'd1,          FILL_RANDOM,  2'd0, 1'b0, KIND_POINT},
    '{SEC_TC_TABLE, 1'b1, FMT_TC_TABLE,  32'd0,          FILL_RANDOM,  2'd0, 1'b1, KIND_END},
    '{SEC_BAD_SIG,  1'b1, FMT_3D_IDX,    32'd0,          FILL_RANDOM,  2'd0, 1'b1, KIND_BAD_SIG},
    '{SEC_FRAME,    1'b1, FMT_3D_TC,     32'd1,          FILL_EXTREME, 2'd0, 1'b0, KIND_POINT}
  };

  logic     clk = 1'b0;
  logic     rst;
  logic     byte_valid;
  logic     byte_stall;
  byte_t    byte_data;
  logic     point_valid;
  logic     point_stall = 1'b0;
  point_t   point_data;

  ilda_laser_frame_stream_parser_core dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .point_valid(point_valid),
    .point_stall(point_stall),
    .point_data (point_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Parser prediction state
  // ---------------------------------------------------------------------------
  parse_st_e         ph;
  logic [4:0]        hdr_pos;
  logic [31:0]       cur_fmt;
  logic [15:0]       frame_len;
  logic [15:0]       pts_done;
  logic [31:0]       left_cnt;
  logic [47:0]       coord_sr;
  logic [31:0]       tail_sr;
  logic [23:0]       rgb_sr;
  logic [23:0]       lut [PALETTE_DEPTH];
  logic [PAL_CW-1:0] lut_cnt;
  logic [15:0]       frame_no;
  logic              stopped;
  logic              sig_err;

  point_t      expected_points [$];
  logic        typed_on = 1'b0;
  point_t      typed_res;
  int unsigned bytes_sent = 0;
  int unsigned live_bytes = 0;
  int unsigned points_checked = 0;
  int unsigned halts_checked = 0;
  int unsigned fails = 0;
  int          calm_left = 0;
  int          stall_left = 0;
  logic        stall_on = 1'b0;

  function automatic void parser_clear();
    ph        = ST_SIG;
    hdr_pos   = '0;
    cur_fmt   = '0;
    frame_len = '0;
    pts_done  = '0;
    left_cnt  = '0;
    coord_sr  = '0;
    tail_sr   = '0;
    rgb_sr    = '0;
    lut_cnt   = '0;
    frame_no  = '0;
    stopped   = 1'b0;
    sig_err   = 1'b0;
  endfunction

  // Advance to a phase; a fresh section start also forgets a signature error.
  function automatic void enter(input parse_st_e s);
    ph      = s;
    hdr_pos = '0;
    if (s == ST_SIG) sig_err = 1'b0;
  endfunction

  function automatic point_t halt_with(input logic [1:0] k);
    point_t p;
    p       = '0;
    p.kind  = k;
    stopped = 1'b1;
    ph      = ST_HALT;
    return p;
  endfunction

  // Consume one file byte; return 1 with the record it completes, if any.
  function automatic logic parse_byte(input logic [7:0] b, input logic rs,
                                      output point_t res);
    logic [4:0]  pos;
    logic [4:0]  cbytes;
    logic [4:0]  rec_len;
    logic        is3d;
    logic        istc;
    logic [23:0] c;
    res = '0;
    if (rs) parser_clear();
    if (stopped) return 1'b0;
    live_bytes++;
    pos  = hdr_pos;
    is3d = (cur_fmt == FMT_3D_IDX) || (cur_fmt == FMT_3D_TC);
    istc = (cur_fmt == FMT_3D_TC) || (cur_fmt == FMT_2D_TC);
    case (ph)
      ST_SIG: begin
        if (b != SIG_BYTES[pos[1:0]]) sig_err = 1'b1;
        hdr_pos = pos + 5'd1;
        if (pos >= SIG_LAST) begin
          if (sig_err) begin
            res = halt_with(KIND_BAD_SIG);
            return 1'b1;
          end
          enter(ST_FMT);
          cur_fmt = '0;
        end
      end
      ST_FMT: begin
        cur_fmt = {cur_fmt[23:0], b};
        hdr_pos = pos + 5'd1;
        if (pos >= FMT_LAST) begin
          frame_len = '0;
          left_cnt  = '0;
          if (cur_fmt <= FMT_2D_IDX || cur_fmt == FMT_3D_TC || cur_fmt == FMT_2D_TC)
            enter(ST_FRAME_HDR);
          else if (cur_fmt == FMT_PALETTE)
            enter(ST_PAL_HDR);
          else if (cur_fmt == FMT_TC_TABLE)
            enter(ST_TC_HDR);
          else
            enter(ST_UNK_HDR);
        end
      end
      ST_FRAME_HDR: begin
        if (pos == HDR_COUNT_HI || pos == HDR_COUNT_LO) frame_len = {frame_len[7:0], b};
        hdr_pos = pos + 5'd1;
        if (pos >= HDR_LAST) begin
          if (frame_len == '0) begin
            res = halt_with(KIND_END);
            return 1'b1;
          end
          pts_done = '0;
          coord_sr = '0;
          tail_sr  = '0;
          enter(ST_POINT);
        end
      end
      ST_POINT: begin
        cbytes  = is3d ? COORD_3D_BYTES : COORD_2D_BYTES;
        rec_len = cbytes + (istc ? TAIL_TC_BYTES : TAIL_IDX_BYTES);
        if (pos < cbytes) coord_sr = {coord_sr[39:0], b};
        else tail_sr = {tail_sr[23:0], b};
        hdr_pos = pos + 5'd1;
        if (pos + 5'd1 >= rec_len) begin
          res.kind = KIND_POINT;
          if (is3d) begin
            res.pos_x = coord_sr[47:32];
            res.pos_y = coord_sr[31:16];
            res.pos_z = coord_sr[15:0];
          end else begin
            res.pos_x = coord_sr[31:16];
            res.pos_y = coord_sr[15:0];
          end
          if (istc) begin
            // status, blue, green, red
            res.blanked   = tail_sr[30];
            res.blue      = tail_sr[23:16];
            res.green     = tail_sr[15:8];
            res.red       = tail_sr[7:0];
            res.has_color = 1'b1;
          end else begin
            // status, index; color comes from the palette slot of this point
            res.blanked     = tail_sr[14];
            res.color_index = tail_sr[7:0];
            if (32'(pts_done) < 32'(lut_cnt)) begin
              c             = lut[pts_done[PAL_AW-1:0]];
              res.red       = c[23:16];
              res.green     = c[15:8];
              res.blue      = c[7:0];
              res.has_color = 1'b1;
            end
          end
          res.frame_number = frame_no;
          res.last_point   = ({1'b0, pts_done} + 17'd1) == {1'b0, frame_len};
          pts_done = pts_done + 16'd1;
          coord_sr = '0;
          tail_sr  = '0;
          hdr_pos  = '0;
          if (pts_done == frame_len) begin
            frame_no = frame_no + 16'd1;
            enter(ST_SIG);
          end
          return 1'b1;
        end
      end
      ST_PAL_HDR: begin
        if (pos == HDR_COUNT_HI || pos == HDR_COUNT_LO) left_cnt = {16'h0, left_cnt[7:0], b};
        hdr_pos = pos + 5'd1;
        if (pos >= HDR_LAST) begin
          lut_cnt = '0;
          if (left_cnt == '0) begin
            enter(ST_SIG);
          end else begin
            rgb_sr = '0;
            enter(ST_TABLE);
          end
        end
      end
      ST_TC_HDR: begin
        if (pos >= SHORT_HDR_MID) left_cnt = {left_cnt[23:0], b};
        hdr_pos = pos + 5'd1;
        if (pos >= SHORT_HDR_END) begin
          lut_cnt = '0;
          if (left_cnt == '0) begin
            res = halt_with(KIND_END);
            return 1'b1;
          end
          rgb_sr = '0;
          enter(ST_TABLE);
        end
      end
      ST_TABLE: begin
        rgb_sr  = {rgb_sr[15:0], b};
        hdr_pos = pos + 5'd1;
        if (pos >= TRIPLE_LAST) begin
          // drop entries past the palette depth
          if (32'(lut_cnt) < PALETTE_DEPTH) begin
            lut[lut_cnt[PAL_AW-1:0]] = rgb_sr;
            lut_cnt                  = lut_cnt + PAL_CW'(1);
          end
          rgb_sr   = '0;
          hdr_pos  = '0;
          left_cnt = left_cnt - 32'd1;
          if (left_cnt == '0) enter(ST_SIG);
        end
      end
      ST_UNK_HDR: begin
        if (pos < SHORT_HDR_MID) left_cnt = {left_cnt[23:0], b};
        hdr_pos = pos + 5'd1;
        if (pos >= SHORT_HDR_END) begin
          // a zero or negative length skips nothing
          if (left_cnt == '0 || left_cnt[31]) enter(ST_SIG);
          else enter(ST_SKIP);
        end
      end
      ST_SKIP: begin
        left_cnt = left_cnt - 32'd1;
        if (left_cnt == '0) enter(ST_SIG);
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Idle patterns: mostly short gaps, a few long ones, and calm stretches
  // ---------------------------------------------------------------------------
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic int next_gap();
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    calm_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 20);
    return gap_len();
  endfunction

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_on   = ($urandom_range(0, 2) == 0);
      stall_left = stall_on ? gap_len() :
                   (($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) :
                                                   $urandom_range(1, 20));
    end
    stall_left--;
    point_stall = stall_on;
  end

  // ---------------------------------------------------------------------------
  // Byte source
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] fill_byte(input fill_e f);
    case (f)
      FILL_ZERO: return 8'h00;
      FILL_ONES: return 8'hFF;
      FILL_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return 8'h00;
          1: return 8'h7F;
          2: return 8'h80;
          default: return 8'hFF;
        endcase
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Present one byte at a falling edge, hold it until the transfer, then predict.
  task automatic push_byte(input logic [7:0] b, input logic rs);
    int     gap;
    point_t res;
    gap = next_gap();
    @(negedge clk);
    if (gap > 0) begin
      byte_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_valid = 1'b1;
    byte_data  = '{data_byte: b, restart: rs};
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    bytes_sent++;
    if (parse_byte(b, rs, res)) begin
      if (typed_on) begin
        expected_points.push_back(typed_res);
        typed_on = 1'b0;
      end else begin
        expected_points.push_back(res);
      end
    end
  endtask

  // Build one section byte by byte; cut > 0 truncates it after that many bytes.
  task automatic send_section(input section_e sec, input logic rs, input logic [31:0] fmt,
                              input logic [31:0] cnt, input fill_e fill,
                              input logic [1:0] bad_at, input int cut);
    logic [7:0]  q [$];
    int unsigned i;
    int unsigned body;
    int unsigned n;
    for (i = 0; i < 4; i++) q.push_back(SIG_BYTES[i]);
    if (sec == SEC_BAD_SIG) begin
      q[bad_at] = q[bad_at] ^ 8'($urandom_range(1, 255));
    end else begin
      q.push_back(fmt[31:24]);
      q.push_back(fmt[23:16]);
      q.push_back(fmt[15:8]);
      q.push_back(fmt[7:0]);
      case (sec)
        SEC_FRAME, SEC_PALETTE: begin
          for (i = 0; i < 24; i++)
            q.push_back(i == HDR_COUNT_HI ? cnt[15:8] :
                        i == HDR_COUNT_LO ? cnt[7:0] : fill_byte(fill));
          if (sec == SEC_PALETTE)
            body = 3;
          else
            body = ((fmt == FMT_3D_IDX || fmt == FMT_3D_TC) ? 6 : 4) +
                   ((fmt == FMT_3D_TC || fmt == FMT_2D_TC) ? 4 : 2);
          body = body * cnt;
        end
        SEC_TC_TABLE: begin
          for (i = 0; i < 4; i++) q.push_back(fill_byte(fill));
          q.push_back(cnt[31:24]);
          q.push_back(cnt[23:16]);
          q.push_back(cnt[15:8]);
          q.push_back(cnt[7:0]);
          body = 3 * cnt;
        end
        default: begin
          q.push_back(cnt[31:24]);
          q.push_back(cnt[23:16]);
          q.push_back(cnt[15:8]);
          q.push_back(cnt[7:0]);
          for (i = 0; i < 4; i++) q.push_back(fill_byte(fill));
          body = (cnt[31]) ? 0 : cnt;
        end
      endcase
      for (i = 0; i < body; i++) q.push_back(fill_byte(fill));
    end
    n = (cut > 0 && cut < q.size()) ? cut : q.size();
    for (i = 0; i < n; i++) push_byte(q[i], rs && (i == 0));
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [15:0] e,
                                      input logic [15:0] a);
    if (e !== a) begin
      fails++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, e, a);
    end
  endfunction

  always @(posedge clk) begin : result_check
    point_t want;
    if (!rst && point_valid && !point_stall) begin
      if (expected_points.size() == 0) begin
        fails++;
        $display("%0t: result with none expected, expected none, actual kind %0d x %0d",
                 $time, point_data.kind, point_data.pos_x);
      end else begin
        want = expected_points.pop_front();
        check_field("kind", want.kind, point_data.kind);
        check_field("pos_x", want.pos_x, point_data.pos_x);
        check_field("pos_y", want.pos_y, point_data.pos_y);
        check_field("pos_z", want.pos_z, point_data.pos_z);
        check_field("red", want.red, point_data.red);
        check_field("green", want.green, point_data.green);
        check_field("blue", want.blue, point_data.blue);
        check_field("blanked", want.blanked, point_data.blanked);
        check_field("has_color", want.has_color, point_data.has_color);
        check_field("color_index", want.color_index, point_data.color_index);
        check_field("frame_number", want.frame_number, point_data.frame_number);
        check_field("last_point", want.last_point, point_data.last_point);
        if (want.kind == KIND_POINT) points_checked++;
        else halts_checked++;
      end
    end
  end

  // End the run when no transfer happens on either side for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((byte_valid && !byte_stall) || (point_valid && !point_stall)) idle = 0;
      else idle++;
    end
    $display("%0t: no transfer for %0d cycles, %0d results outstanding",
             $time, IDLE_LIMIT, expected_points.size());
    $display("** ilda_laser_frame_stream_parser_core: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned    r;
    int unsigned    sel;
    int unsigned    k;
    int unsigned    live_mark;
    logic           rs;
    logic           need_restart;
    logic [31:0]    fmt;
    logic [31:0]    cnt;
    fill_e          fill;
    plan_row_t      row;
    rst          = 1'b1;
    byte_valid   = 1'b0;
    byte_data    = '0;
    need_restart = 1'b0;
    parser_clear();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed sections; halt rows carry their expected record.
    for (r = 0; r < PLAN_ROWS; r++) begin
      row            = PLAN[r];
      typed_on       = row.typed;
      typed_res      = '0;
      typed_res.kind = row.typed_kind;
      send_section(row.sec, row.restart, row.fmt, row.count, row.fill, row.bad_at, 0);
      typed_on = 1'b0;
    end

    // Random file: mostly well-formed sections, some halts, noise and cut sections.
    live_mark    = live_bytes;
    need_restart = 1'b1;
    while (live_bytes < live_mark + RANDOM_BYTES) begin
      if (stopped && $urandom_range(0, 3) == 0) begin
        // drop a few bytes while halted
        k = $urandom_range(1, 5);
        for (r = 0; r < k; r++) push_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      rs           = need_restart || ($urandom_range(0, 24) == 0);
      need_restart = 1'b0;
      fill         = ($urandom_range(0, 9) == 0) ? FILL_EXTREME : FILL_RANDOM;
      case ($urandom_range(0, 3))
        0: fmt = FMT_3D_IDX;
        1: fmt = FMT_2D_IDX;
        2: fmt = FMT_3D_TC;
        default: fmt = FMT_2D_TC;
      endcase
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        send_section(SEC_FRAME, rs, fmt, cnt, fill, 2'd0, 0);
      end else if (sel < 67) begin
        k = $urandom_range(0, 9);
        cnt = (k == 0) ? 32'd0 : (k == 1) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        send_section(SEC_PALETTE, rs, FMT_PALETTE, cnt, fill, 2'd0, 0);
      end else if (sel < 75) begin
        send_section(SEC_TC_TABLE, rs, FMT_TC_TABLE, $urandom_range(1, 8), fill, 2'd0, 0);
      end else if (sel < 83) begin
        fmt = ($urandom_range(0, 1) == 0) ? $urandom_range(6, 255) : ($urandom() | 32'h100);
        k = $urandom_range(0, 9);
        cnt = (k == 0) ? ($urandom() | 32'h8000_0000) : (k == 1) ? 32'd0 :
              $urandom_range(1, 16);
        send_section(SEC_UNKNOWN, rs, fmt, cnt, fill, 2'd0, 0);
      end else if (sel < 86) begin
        send_section(SEC_BAD_SIG, rs, fmt, 32'd0, fill, 2'($urandom_range(0, 3)), 0);
        need_restart = 1'b1;
      end else if (sel < 89) begin
        if ($urandom_range(0, 1) == 0)
          send_section(SEC_FRAME, rs, fmt, 32'd0, fill, 2'd0, 0);
        else
          send_section(SEC_TC_TABLE, rs, FMT_TC_TABLE, 32'd0, fill, 2'd0, 0);
        need_restart = 1'b1;
      end else if (sel < 95) begin
        // cut a section short; the next one restarts the file
        send_section(SEC_FRAME, rs, fmt, $urandom_range(1, 4), fill, 2'd0,
                     $urandom_range(1, 40));
        need_restart = 1'b1;
      end else begin
        k = $urandom_range(1, 10);
        for (r = 0; r < k; r++)
          push_byte(8'($urandom_range(0, 255)), (r == 0) ? rs : ($urandom_range(0, 7) == 0));
        need_restart = 1'b1;
      end
    end

    @(negedge clk);
    byte_valid = 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d byte transfers (%0d parsed): indexed and true-color frames,",
             bytes_sent, live_bytes);
    $display("color tables, skipped sections, restarts; %0d points and %0d halts checked.",
             points_checked, halts_checked);
    if (fails == 0)
      $display("** ilda_laser_frame_stream_parser_core: PASSED **");
    else
      $display("** ilda_laser_frame_stream_parser_core: FAILED **");
    $finish;
  end

endmodule
